FILE: hdl/sfr_pkg.sv
// sfr_pkg: shared constants and field widths for the sensor frame receiver.
// No dependencies; used by the interfaces and by the top level.
package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;

  localparam int MAX_LEN = 24;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h68;

  localparam logic [STAT_W-1:0] ST_PROGRESS = 2'd0;
  localparam logic [STAT_W-1:0] ST_GOOD     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD      = 2'd2;

endpackage

FILE: hdl/sfr_if.sv
// sfr_if: valid/ready channel interfaces for the sensor frame receiver
// (byte input, result output, address configuration). Depends on sfr_pkg.
interface sfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::STAT_W-1:0] status;
  logic [sfr_pkg::POS_W-1:0]  byte_position;
  logic [sfr_pkg::BYTE_W-1:0] byte_value;
  logic [sfr_pkg::POS_W-1:0]  frame_length;

  modport source (output valid, output status, output byte_position, output byte_value,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input byte_position, input byte_value,
                  input frame_length, output ready);
endinterface

interface sfr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::BYTE_W-1:0] device_address;

  modport source (output valid, output device_address, input ready);
  modport sink   (input valid, input device_address, output ready);
endinterface

FILE: hdl/sensor_frame_receiver.sv
// sensor_frame_receiver: delimits header/length/address/sum8 sensor reply frames.
// Depends on sfr_pkg and the channel interfaces in sfr_if.sv.
//
// Usage:
//   in_chan  : one received serial byte per transaction (rx_byte).
//   out_chan : one result per input byte: status (0 in progress, 1 frame good,
//              2 rejected or bad), byte_position, byte_value (echo) and
//              frame_length (nonzero only with status 1).
//   cfg_chan : writes device_address; always ready. Write only while idle.
// Timing:
//   A byte enters an input register, is checked against the frame state by
//   one level of compare and 8-bit add logic, and then moves to the result
//   register that drives out_chan.valid. One byte per cycle is sustained
//   while out_chan.ready is high; the frame state updates in the same cycle
//   a byte moves to the result register.
// Reset: rst_n (synchronous, active low) empties both registers, clears the
//   frame state to position 0 and device_address to 0.
// Stall: while out_chan.ready is low the result holds and one more byte is
//   taken into the input register; then in_chan.ready drops.
module sensor_frame_receiver (
  input  logic      clk,
  input  logic      rst_n,
  sfr_in_if.sink    in_chan,
  sfr_out_if.source out_chan,
  sfr_cfg_if.sink   cfg_chan
);

  logic                       in_valid_r;
  logic [sfr_pkg::BYTE_W-1:0] in_byte_r;

  logic [sfr_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [sfr_pkg::POS_W-1:0]  exp_len_r, exp_len_nxt;
  logic [sfr_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [sfr_pkg::BYTE_W-1:0] dev_addr_r;

  logic                       out_valid_r;
  logic [sfr_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [sfr_pkg::POS_W-1:0]  out_pos_r;
  logic [sfr_pkg::BYTE_W-1:0] out_byte_r;
  logic [sfr_pkg::POS_W-1:0]  out_len_r, out_len_nxt;

  logic                       advance;
  logic [sfr_pkg::POS_W-1:0]  len_cur;
  logic                       bad_early;

  assign advance        = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !in_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign len_cur = (pos_r == sfr_pkg::POS_W'(1)) ? in_byte_r[sfr_pkg::POS_W-1:0] : exp_len_r;

  assign bad_early =
      ((pos_r == sfr_pkg::POS_W'(1)) &&
       ((in_byte_r == '0) || (in_byte_r > sfr_pkg::BYTE_W'(sfr_pkg::MAX_LEN)))) ||
      ((pos_r == sfr_pkg::POS_W'(2)) && (in_byte_r != dev_addr_r)) ||
      (len_cur == '0) || (pos_r > len_cur);

  always_comb begin
    pos_nxt     = '0;
    exp_len_nxt = '0;
    sum_nxt     = '0;
    status_nxt  = sfr_pkg::ST_BAD;
    out_len_nxt = '0;
    if (pos_r == '0) begin
      if (in_byte_r == sfr_pkg::HEADER_BYTE) begin
        pos_nxt    = sfr_pkg::POS_W'(1);
        status_nxt = sfr_pkg::ST_PROGRESS;
      end
    end else if (!bad_early) begin
      if (pos_r == len_cur) begin
        if (in_byte_r == sum_r) begin
          status_nxt  = sfr_pkg::ST_GOOD;
          out_len_nxt = len_cur;
        end
      end else begin
        pos_nxt     = pos_r + sfr_pkg::POS_W'(1);
        exp_len_nxt = len_cur;
        sum_nxt     = sum_r + in_byte_r;
        status_nxt  = sfr_pkg::ST_PROGRESS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      exp_len_r   <= '0;
      sum_r       <= '0;
      dev_addr_r  <= '0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        exp_len_r   <= exp_len_nxt;
        sum_r       <= sum_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        dev_addr_r <= cfg_chan.device_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
    end
    if (advance) begin
      status_r   <= status_nxt;
      out_pos_r  <= pos_r;
      out_byte_r <= in_byte_r;
      out_len_r  <= out_len_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.byte_position = out_pos_r;
  assign out_chan.byte_value    = out_byte_r;
  assign out_chan.frame_length  = out_len_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= sfr_pkg::POS_W'(sfr_pkg::MAX_LEN))
    else $error("frame position beyond maximum length");

  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == sfr_pkg::ST_GOOD) |->
      (out_len_r == out_pos_r) && (out_len_r != '0))
    else $error("good frame length does not match checksum position");

  a_resync: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (status_nxt != sfr_pkg::ST_PROGRESS) |=> (pos_r == '0) && (sum_r == '0))
    else $error("receiver did not resynchronize after frame end");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_chan.ready |=> in_valid_r && $stable(in_byte_r))
    else $error("pending byte lost while result stalled");

endmodule
